>>> hw/rtl/phong_fragment_shader_core_assert.svh
// ----------------------------------------------------------------------------
// Phong shader assertion macros
// Shared concurrent check forms, clocked on clk and held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef PHONG_FRAGMENT_SHADER_CORE_ASSERT_SVH
`define PHONG_FRAGMENT_SHADER_CORE_ASSERT_SVH

// Same-cycle implication
`define PHONG_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication
`define PHONG_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> hw/rtl/phong_pkg.sv
// ----------------------------------------------------------------------------
// Phong shader package
// Beat types, register and light codes, and small fixed-point helpers.
// ----------------------------------------------------------------------------
package phong_pkg;

	localparam int SHINE_BITS_DEF = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int MUL_W          = 34;
	localparam int PROD_W         = 2 * MUL_W;

	localparam logic [31:0] ONE_Q14 = 32'd16384;

	// Light kinds
	localparam logic [1:0] KIND_AMBIENT     = 2'd0;
	localparam logic [1:0] KIND_POINT       = 2'd1;
	localparam logic [1:0] KIND_DIRECTIONAL = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPECULAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHINE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW     = 3'd4;

	typedef struct packed {
		logic [1:0]  light_kind;
		logic [47:0] light_vector;
		logic [47:0] light_color;
		logic [47:0] surface_normal;
		logic [47:0] surface_point;
		logic        last_light;
	} phong_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} phong_out_t;

	typedef struct packed {
		logic                    en;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

	// Pick one 16-bit lane of a packed triple
	function automatic logic [15:0] comp16(input logic [47:0] v, input logic [1:0] c);
		logic [15:0] r;
		case (c)
			2'd0:    r = v[15:0];
			2'd1:    r = v[31:16];
			2'd2:    r = v[47:32];
			default: r = v[15:0];
		endcase
		return r;
	endfunction

	function automatic logic signed [MUL_W-1:0] sx16(input logic [15:0] v);
		return {{(MUL_W-16){v[15]}}, v};
	endfunction

	function automatic logic signed [MUL_W-1:0] sx17(input logic [16:0] v);
		return {{(MUL_W-17){v[16]}}, v};
	endfunction

	function automatic logic signed [MUL_W-1:0] zx16(input logic [15:0] v);
		return {{(MUL_W-16){1'b0}}, v};
	endfunction

	function automatic logic signed [MUL_W-1:0] zx32(input logic [31:0] v);
		return {{(MUL_W-32){1'b0}}, v};
	endfunction

	// Q.14 product, floored and saturated to 32 bits
	function automatic logic [31:0] mul14(input logic signed [PROD_W-1:0] p);
		logic [31:0] r;
		if (|p[PROD_W-1:46])
			r = 32'hFFFF_FFFF;
		else
			r = p[45:14];
		return r;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

>>> hw/rtl/phong_mul.sv
// ----------------------------------------------------------------------------
// Phong shared multiplier
// Signed 34 x 34 multiply with the product registered on request.
// ----------------------------------------------------------------------------
module phong_mul (
	input  logic                                       clk,
	input  phong_pkg::mul_req_t                        req,
	output logic signed [phong_pkg::PROD_W-1:0]        prod
);
	import phong_pkg::*;

	// Capture the product of the issued operands
	always_ff @(posedge clk) begin
		if (req.en)
			prod <= PROD_W'(req.a) * PROD_W'(req.b);
	end

endmodule

>>> hw/rtl/phong_fragment_shader_core.sv
// ----------------------------------------------------------------------------
// Phong fragment shader core
// Per-light Phong terms summed per fragment, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat pairs a fragment with one light; last_light closes the
//           fragment and produces one RGBA beat on out_*.
//   cfg_* : register writes (coefficients, shininess, view), always ready;
//           write only while the core is idle.
//   An item is taken only in the idle state; in_ready drops until it is done.
//   Ambient light: three multiplies, one per colour component.
//   Point or directional light: the work runs through the single multiplier,
//   the 25-step square root, three restoring divisions for the unit vector
//   and a power loop over the SHINE_BITS exponent bits.
//   A closing light also passes the emit state; the result sits in an output
//   register, so the next light is taken while the result waits.
//   If the receiver stalls with an earlier result still held, the core waits
//   in the emit state until out_ready frees the register.
//   Reset clears the sums, the output valid and the registers (shininess 1).
// ----------------------------------------------------------------------------
`include "phong_fragment_shader_core_assert.svh"

module phong_fragment_shader_core #(
	parameter int SHINE_BITS = phong_pkg::SHINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  phong_pkg::phong_in_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output phong_pkg::phong_out_t             out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [phong_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [47:0]                       cfg_data
);
	import phong_pkg::*;

	localparam int PC_W = $clog2(SHINE_BITS + 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_AMB  = 10'b00_0000_0010,
		ST_SQ   = 10'b00_0000_0100,
		ST_SQRT = 10'b00_0000_1000,
		ST_DIV  = 10'b00_0001_0000,
		ST_DOT  = 10'b00_0010_0000,
		ST_REFL = 10'b00_0100_0000,
		ST_POW  = 10'b00_1000_0000,
		ST_COL  = 10'b01_0000_0000,
		ST_EMIT = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	logic                ph_q;
	logic [1:0]          comp_q;
	logic [3:0]          step_q;
	logic [PC_W-1:0]     pcnt_q;
	logic [31:0]         sum_q [3];
	logic                out_valid_q;
	phong_out_t          out_q;

	logic [47:0] ka_q, kd_q, ks_q, view_q;
	logic [7:0]  shin_q;

	logic        last_q;
	logic [47:0] col_q, nrm_q;
	logic [16:0] lv_q [3];
	logic [33:0] sq_q;
	logic [50:0] x_q, r_q, b_q;
	logic [24:0] len_q;
	logic [38:0] rem_q, dsh_q;
	logic [14:0] quo_q;
	logic        ovf_q;
	logic signed [15:0] ln_q [3];
	logic signed [31:0] acc_q;
	logic signed [32:0] rr_q;
	logic signed [49:0] rv_q;
	logic [31:0] base_q, pw_q, tmp_q;
	logic [SHINE_BITS-1:0] exp_q;

	mul_req_t                   mreq;
	logic signed [PROD_W-1:0]   prod;
	logic [31:0]                prod14;

	logic        in_beat, emit_go, last_comp, busy_go;
	state_t      fin_state;
	logic signed [23:0] dot;
	logic [33:0] dc;
	logic [15:0] ncomp, icomp, vcomp;
	logic [16:0] nv;
	logic [33:0] sq_nx;
	logic [50:0] rb, x_n, r_n;
	logic [15:0] mag;
	logic        ge;
	logic [14:0] quo_n, qv;
	logic signed [15:0] ln_n;
	logic signed [49:0] rv_nx;
	logic signed [41:0] rs;
	logic [31:0] base_n;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign last_comp = (comp_q == 2'd2);
	assign fin_state = last_q ? ST_EMIT : ST_IDLE;
	assign prod14    = mul14(prod);
	// a beat that keeps the core busy: a real light or a closing one
	assign busy_go   = in_beat && ((in_data.light_kind == KIND_AMBIENT) ||
		(in_data.light_kind == KIND_POINT) ||
		(in_data.light_kind == KIND_DIRECTIONAL) || in_data.last_light);

	// Shared multiplier
	phong_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	// Derived operands
	always_comb begin
		ncomp  = comp16(nrm_q, comp_q);
		icomp  = comp16(col_q, comp_q);
		vcomp  = comp16(view_q, comp_q);
		nv     = 17'd0 - {vcomp[15], vcomp};
		dot    = acc_q[31:8];
		dc     = dot[23] ? 34'd0 : {10'd0, dot};
		sq_nx  = sq_q + prod[33:0];
		rv_nx  = rv_q + prod[49:0];
		rs     = rv_nx[49:8];
		if (rs[41])
			base_n = 32'd0;
		else if (|rs[40:32])
			base_n = 32'hFFFF_FFFF;
		else
			base_n = rs[31:0];
	end

	// Square root step
	always_comb begin
		rb = r_q + b_q;
		if (x_q >= rb) begin
			x_n = x_q - rb;
			r_n = (r_q >> 1) + b_q;
		end else begin
			x_n = x_q;
			r_n = r_q >> 1;
		end
	end

	// Division step and unit component
	always_comb begin
		mag   = lv_q[comp_q][16] ? 16'(17'd0 - lv_q[comp_q]) : lv_q[comp_q][15:0];
		ge    = (rem_q >= dsh_q);
		quo_n = {quo_q[13:0], ge};
		qv    = (ovf_q || (quo_n > 15'd16384)) ? 15'd16384 : quo_n;
		if (len_q == 25'd0)
			ln_n = 16'sd0;
		else if (lv_q[comp_q][16])
			ln_n = 16'sd0 - $signed({1'b0, qv});
		else
			ln_n = $signed({1'b0, qv});
	end

	// Operand selection for the shared multiplier
	always_comb begin
		mreq.en = !ph_q;
		mreq.a  = '0;
		mreq.b  = '0;
		case (state_q)
			ST_AMB: begin
				mreq.a = zx16(comp16(ka_q, comp_q));
				mreq.b = zx16(icomp);
			end
			ST_SQ: begin
				mreq.a = sx17(lv_q[comp_q]);
				mreq.b = sx17(lv_q[comp_q]);
			end
			ST_DOT: begin
				mreq.a = sx16(ncomp);
				mreq.b = sx16(ln_q[comp_q]);
			end
			ST_REFL: begin
				if (!step_q[0]) begin
					mreq.a = {{9{dot[23]}}, dot, 1'b0};
					mreq.b = sx16(ncomp);
				end else begin
					mreq.a = {rr_q[32], rr_q};
					mreq.b = sx17(nv);
				end
			end
			ST_POW: begin
				mreq.a = zx32(pw_q);
				mreq.b = step_q[0] ? zx32(base_q) : zx32(pw_q);
			end
			ST_COL: begin
				case (step_q[1:0])
					2'd0: begin
						mreq.a = zx16(comp16(kd_q, comp_q));
						mreq.b = zx16(icomp);
					end
					2'd1: begin
						mreq.a = zx32(tmp_q);
						mreq.b = dc;
					end
					2'd2: begin
						mreq.a = zx16(comp16(ks_q, comp_q));
						mreq.b = zx16(icomp);
					end
					default: begin
						mreq.a = zx32(tmp_q);
						mreq.b = zx32(pw_q);
					end
				endcase
			end
			default: mreq.en = 1'b0;
		endcase
	end

	// Sequencer, sums, registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= 1'b0;
			comp_q      <= 2'd0;
			step_q      <= 4'd0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
			sum_q[0]    <= 32'd0;
			sum_q[1]    <= 32'd0;
			sum_q[2]    <= 32'd0;
			ka_q        <= 48'd0;
			kd_q        <= 48'd0;
			ks_q        <= 48'd0;
			shin_q      <= 8'd1;
			view_q      <= 48'd0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_AMBIENT:  ka_q   <= cfg_data;
					REG_DIFFUSE:  kd_q   <= cfg_data;
					REG_SPECULAR: ks_q   <= cfg_data;
					REG_SHINE:    shin_q <= cfg_data[7:0];
					REG_VIEW:     view_q <= cfg_data;
					default:      ;
				endcase
			end

			// raise the result on emit, drop it once taken
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						comp_q <= 2'd0;
						step_q <= 4'd0;
						ph_q   <= 1'b0;
						case (in_data.light_kind)
							KIND_AMBIENT:                 state_q <= ST_AMB;
							KIND_POINT, KIND_DIRECTIONAL: state_q <= ST_SQ;
							default: state_q <= in_data.last_light ? ST_EMIT : ST_IDLE;
						endcase
					end
				end
				ST_AMB: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						sum_q[comp_q] <= sat_add(sum_q[comp_q], prod14);
						comp_q        <= last_comp ? 2'd0 : comp_q + 2'd1;
						if (last_comp)
							state_q <= fin_state;
					end
				end
				ST_SQ, ST_DOT: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
						if (last_comp) begin
							state_q <= (state_q == ST_SQ) ? ST_SQRT : ST_REFL;
							step_q  <= 4'd0;
						end
					end
				end
				ST_SQRT: begin
					if (b_q[0]) begin
						state_q <= ST_DIV;
						ph_q    <= 1'b0;
						comp_q  <= 2'd0;
					end
				end
				ST_DIV: begin
					if (!ph_q) begin
						ph_q   <= 1'b1;
						step_q <= 4'd0;
					end else begin
						step_q <= step_q + 4'd1;
						if (step_q == 4'd14) begin
							ph_q   <= 1'b0;
							comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
							if (last_comp)
								state_q <= ST_DOT;
						end
					end
				end
				ST_REFL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						step_q <= {3'd0, !step_q[0]};
						if (step_q[0]) begin
							comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
							if (last_comp) begin
								state_q <= ST_POW;
								pcnt_q  <= PC_W'(SHINE_BITS);
							end
						end
					end
				end
				ST_POW: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (!step_q[0] && exp_q[SHINE_BITS-1]) begin
							step_q <= 4'd1;
						end else begin
							step_q <= 4'd0;
							pcnt_q <= pcnt_q - PC_W'(1);
							if (pcnt_q == PC_W'(1)) begin
								state_q <= ST_COL;
								comp_q  <= 2'd0;
							end
						end
					end
				end
				ST_COL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						step_q <= {2'd0, step_q[1:0] + 2'd1};
						if (step_q[0])
							sum_q[comp_q] <= sat_add(sum_q[comp_q], prod14);
						if (step_q[1:0] == 2'd3) begin
							comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
							if (last_comp)
								state_q <= fin_state;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						sum_q[0]    <= 32'd0;
						sum_q[1]    <= 32'd0;
						sum_q[2]    <= 32'd0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Clamp a sum to 1.0 and scale to a byte
	function automatic logic [7:0] to_byte(input logic [31:0] s);
		logic [14:0] v;
		logic [22:0] w;
		v = (s > ONE_Q14) ? 15'd16384 : s[14:0];
		w = {v, 8'd0} - {8'd0, v};
		return w[21:14];
	endfunction

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					last_q <= in_data.last_light;
					col_q  <= in_data.light_color;
					nrm_q  <= in_data.surface_normal;
					sq_q   <= 34'd0;
					for (int c = 0; c < 3; c++) begin
						if (in_data.light_kind == KIND_POINT)
							lv_q[c] <= {in_data.light_vector[16*c+15], in_data.light_vector[16*c +: 16]}
								- {in_data.surface_point[16*c+15], in_data.surface_point[16*c +: 16]};
						else
							lv_q[c] <= {in_data.light_vector[16*c+15], in_data.light_vector[16*c +: 16]};
					end
				end
			end
			ST_SQ: begin
				if (ph_q) begin
					sq_q <= sq_nx;
					if (last_comp) begin
						x_q <= {1'b0, sq_nx, 16'd0};
						r_q <= 51'd0;
						b_q <= 51'd1 << 48;
					end
				end
			end
			ST_SQRT: begin
				x_q <= x_n;
				r_q <= r_n;
				b_q <= b_q >> 2;
				if (b_q[0])
					len_q <= r_n[24:0];
			end
			ST_DIV: begin
				if (!ph_q) begin
					rem_q <= {1'b0, mag, 22'd0};
					dsh_q <= {len_q, 14'd0};
					quo_q <= 15'd0;
					ovf_q <= ({2'd0, mag, 7'd0} >= len_q);
				end else begin
					if (ge)
						rem_q <= rem_q - dsh_q;
					dsh_q <= dsh_q >> 1;
					quo_q <= quo_n;
					if (step_q == 4'd14)
						ln_q[comp_q] <= ln_n;
				end
			end
			ST_DOT: begin
				if (ph_q)
					acc_q <= ((comp_q == 2'd0) ? 32'sd0 : acc_q) + prod[31:0];
			end
			ST_REFL: begin
				if (ph_q && !step_q[0])
					rr_q <= prod[40:8] - {{17{ln_q[comp_q][15]}}, ln_q[comp_q]};
				if (ph_q && step_q[0]) begin
					rv_q <= ((comp_q == 2'd0) ? 50'sd0 : rv_q) + prod[49:0];
					if (last_comp) begin
						base_q <= base_n;
						pw_q   <= ONE_Q14;
						exp_q  <= SHINE_BITS'(shin_q);
					end
				end
			end
			ST_POW: begin
				if (ph_q) begin
					pw_q <= prod14;
					if (step_q[0] || !exp_q[SHINE_BITS-1])
						exp_q <= exp_q << 1;
				end
			end
			ST_COL: begin
				if (ph_q && !step_q[0])
					tmp_q <= prod14;
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_q.red   <= to_byte(sum_q[0]);
					out_q.green <= to_byte(sum_q[1]);
					out_q.blue  <= to_byte(sum_q[2]);
					out_q.alpha <= 8'hFF;
				end
			end
			default: ;
		endcase
	end

	// Checks
	`PHONG_ASSERT_NXT(a_busy_after_accept, busy_go, !in_ready, "core ready right after taking a beat")
	`PHONG_ASSERT_IMP(a_unit_range, state_q == ST_DOT, ln_q[0] <= 16'sd16384 && ln_q[0] >= -16'sd16384 && ln_q[1] <= 16'sd16384 && ln_q[1] >= -16'sd16384 && ln_q[2] <= 16'sd16384 && ln_q[2] >= -16'sd16384, "unit vector component beyond 1.0")
	`PHONG_ASSERT_NXT(a_sums_cleared, emit_go, sum_q[0] == 32'd0 && sum_q[1] == 32'd0 && sum_q[2] == 32'd0 && out_valid_q, "sums not cleared on emit")

endmodule

>>> dv/phong_fragment_shader_core_tb.sv
// ----------------------------------------------------------------------------
// Phong fragment shader core testbench
// Drives light beats with random gaps and register writes, predicts each
// fragment's RGBA pixel with a local fixed-point Phong model and checks every
// output beat against it in order.
// ----------------------------------------------------------------------------
module phong_fragment_shader_core_tb;
	import phong_pkg::*;

	localparam int HALF      = 6;
	localparam int DRAIN_CYC = 200;
	localparam int STALL_MAX = 20000;
	localparam int SHINE_W   = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	phong_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	phong_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;

	// Local copy of the shading state and registers
	logic [31:0] chan_sum [3];
	logic [47:0] k_amb, k_dif, k_spec, view_vec;
	logic [7:0]  shine;

	phong_in_t  lights_pending [$];
	phong_out_t pixels_expected [$];
	logic in_taken = 1'b0;
	logic hold_lights = 1'b0;
	logic no_idle = 1'b0;
	int   errors = 0;
	int   quiet_cycles = 0;

	phong_fragment_shader_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#HALF clk = 1'b1;
		#HALF clk = 1'b0;
	end

	function automatic longint lane_s(logic [47:0] v, int c);
		return longint'($signed(v[16*c +: 16]));
	endfunction

	function automatic longint unsigned lane_u(logic [47:0] v, int c);
		return longint'(v[16*c +: 16]);
	endfunction

	function automatic longint unsigned q14_mul(longint unsigned a, longint unsigned b);
		longint unsigned p;
		p = (a * b) >> 14;
		return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void add_chan(int c, longint unsigned v);
		longint unsigned s;
		s = longint'(chan_sum[c]) + v;
		chan_sum[c] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Diffuse and specular terms of a point or directional light
	function automatic void add_directed(logic point, phong_in_t it);
		longint lv [3], un [3], nv [3];
		longint unsigned sumsq, len, mag, q, dc, pw, col;
		longint dp, rv, r;
		sumsq = 0;
		dp = 0;
		rv = 0;
		for (int c = 0; c < 3; c++) begin
			lv[c] = lane_s(it.light_vector, c) - (point ? lane_s(it.surface_point, c) : 0);
			sumsq += longint'(lv[c] * lv[c]);
			nv[c] = lane_s(it.surface_normal, c);
		end
		len = int_sqrt(sumsq << 16);
		for (int c = 0; c < 3; c++) begin
			if (len == 0) begin
				un[c] = 0;
			end else begin
				mag = (lv[c] < 0) ? -lv[c] : lv[c];
				q = (mag << 22) / len;
				if (q > 16384) q = 16384;
				un[c] = (lv[c] < 0) ? -longint'(q) : longint'(q);
			end
			dp += nv[c] * un[c];
		end
		dp = dp >>> 8;
		dc = (dp > 0) ? dp : 0;
		// Reflection uses the unclamped L.N
		for (int c = 0; c < 3; c++) begin
			r = ((2 * dp * nv[c]) >>> 8) - un[c];
			rv += r * (-lane_s(view_vec, c));
		end
		rv = rv >>> 8;
		if (rv < 0) rv = 0;
		if (rv > 64'sh0_FFFF_FFFF) rv = 64'sh0_FFFF_FFFF;
		pw = 16384;
		for (int k = SHINE_W - 1; k >= 0; k--) begin
			pw = q14_mul(pw, pw);
			if (shine[k]) pw = q14_mul(pw, rv);
		end
		for (int c = 0; c < 3; c++) begin
			col = lane_u(it.light_color, c);
			add_chan(c, q14_mul(q14_mul(lane_u(k_dif, c), col), dc));
			add_chan(c, q14_mul(q14_mul(lane_u(k_spec, c), col), pw));
		end
	endfunction

	// Fold one light into the sums; queue a pixel on the closing light
	function automatic void shade_light(phong_in_t it);
		phong_out_t px;
		longint unsigned v;
		case (it.light_kind)
			KIND_AMBIENT:
				for (int c = 0; c < 3; c++)
					add_chan(c, q14_mul(lane_u(k_amb, c), lane_u(it.light_color, c)));
			KIND_POINT:       add_directed(1'b1, it);
			KIND_DIRECTIONAL: add_directed(1'b0, it);
			default: ;
		endcase
		if (it.last_light) begin
			for (int c = 0; c < 3; c++) begin
				v = (chan_sum[c] > 16384) ? 16384 : chan_sum[c];
				v = (v * 255) >> 14;
				case (c)
					0: px.red = v[7:0];
					1: px.green = v[7:0];
					default: px.blue = v[7:0];
				endcase
				chan_sum[c] = '0;
			end
			px.alpha = 8'd255;
			pixels_expected.push_back(px);
		end
	endfunction

	// Drive light beats at the falling edge
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (lights_pending.size() != 0 && !hold_lights && arst_n &&
			    (no_idle || $urandom_range(99) >= 33)) begin
				in_data <= lights_pending.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= no_idle || ($urandom_range(99) >= 33);
	end

	// Sample beats, predict and check at the rising edge
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready)
			shade_light(in_data);
		if (out_valid && out_ready) begin
			if (pixels_expected.size() == 0) begin
				$error("unexpected pixel %h", out_data);
				errors++;
			end else begin
				phong_out_t want;
				want = pixels_expected.pop_front();
				if (out_data.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, out_data.red);
					errors++;
				end
				if (out_data.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, out_data.green);
					errors++;
				end
				if (out_data.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, out_data.blue);
					errors++;
				end
				if (out_data.alpha !== want.alpha) begin
					$error("alpha: expected %0d, got %0d", want.alpha, out_data.alpha);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [47:0] pack3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		return {c, b, a};
	endfunction

	function automatic logic [47:0] rand_vec();
		logic [47:0] v;
		v = 48'({$urandom, $urandom});
		if ($urandom_range(1) == 0)
			for (int c = 0; c < 3; c++)
				v[16*c +: 16] = 16'($signed($urandom_range(1024)) - 512);
		return v;
	endfunction

	function automatic logic [47:0] rand_colour();
		logic [47:0] v;
		v = 48'({$urandom, $urandom});
		if ($urandom_range(1) == 0)
			for (int c = 0; c < 3; c++)
				v[16*c +: 16] = 16'($urandom_range(16384));
		return v;
	endfunction

	function automatic phong_in_t rand_light();
		phong_in_t it;
		int pick;
		pick = $urandom_range(99);
		it.light_kind = (pick < 20) ? KIND_AMBIENT : (pick < 58) ? KIND_POINT :
		                (pick < 96) ? KIND_DIRECTIONAL : 2'd3;
		it.light_vector = rand_vec();
		it.light_color = rand_colour();
		it.surface_normal = rand_vec();
		it.surface_point = ($urandom_range(9) == 0) ? it.light_vector : rand_vec();
		it.last_light = ($urandom_range(3) == 0);
		return it;
	endfunction

	function automatic phong_in_t mk(logic [1:0] kind, logic [47:0] lv, logic [47:0] col,
	                                 logic [47:0] nrm, logic [47:0] pt, logic last);
		phong_in_t it;
		it.light_kind = kind;
		it.light_vector = lv;
		it.light_color = col;
		it.surface_normal = nrm;
		it.surface_point = pt;
		it.last_light = last;
		return it;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_AMBIENT:  k_amb = val;
			REG_DIFFUSE:  k_dif = val;
			REG_SPECULAR: k_spec = val;
			REG_SHINE:    shine = val[7:0];
			REG_VIEW:     view_vec = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Let the core run dry, then give a trailing light time to finish
	task automatic wait_quiet();
		while (lights_pending.size() != 0 || in_valid || pixels_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic run_random(int n);
		repeat (n) lights_pending.push_back(rand_light());
		wait_quiet();
	endtask

	task automatic set_all(logic [47:0] a, logic [47:0] d, logic [47:0] s,
	                       logic [7:0] sh, logic [47:0] v);
		write_reg(REG_AMBIENT, a);
		write_reg(REG_DIFFUSE, d);
		write_reg(REG_SPECULAR, s);
		write_reg(REG_SHINE, {40'd0, sh});
		write_reg(REG_VIEW, v);
	endtask

	localparam logic [47:0] ONES3 = pack3(16'h4000, 16'h4000, 16'h4000);
	localparam logic [47:0] HALF3 = pack3(16'h2000, 16'h2000, 16'h2000);
	localparam logic [47:0] ZUP   = pack3(16'h0000, 16'h0000, 16'h0100);
	localparam logic [47:0] ZDN   = pack3(16'h0000, 16'h0000, 16'hFF00);
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	initial begin
		k_amb = '0;
		k_dif = '0;
		k_spec = '0;
		view_vec = '0;
		shine = 8'd1;
		for (int c = 0; c < 3; c++) chan_sum[c] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers at their reset values
		run_random(30);

		// Directed lights with half-scale coefficients, viewer looking down -z
		set_all(HALF3, HALF3, HALF3, 8'd4, ZDN);
		lights_pending.push_back(mk(KIND_AMBIENT, '0, ONES3, ZUP, '0, 1'b1));
		lights_pending.push_back(mk(KIND_AMBIENT, '0, MAX48, ZUP, '0, 1'b0));
		lights_pending.push_back(mk(KIND_AMBIENT, '0, MAX48, ZUP, '0, 1'b1));
		lights_pending.push_back(mk(KIND_DIRECTIONAL, ZUP, ONES3, ZUP, '0, 1'b1));
		lights_pending.push_back(mk(KIND_POINT, pack3(16'h0100, 16'h0200, 16'h0300),
		                            ONES3, ZUP, '0, 1'b1));
		// zero-length light vector: point light at the surface point
		lights_pending.push_back(mk(KIND_POINT, ZUP, ONES3, ZUP, ZUP, 1'b1));
		lights_pending.push_back(mk(KIND_DIRECTIONAL, '0, ONES3, ZUP, '0, 1'b1));
		// light from behind the surface: negative L.N
		lights_pending.push_back(mk(KIND_DIRECTIONAL, ZDN, ONES3, ZUP, '0, 1'b1));
		// unused kind still closes the fragment
		lights_pending.push_back(mk(2'd3, MAX48, MAX48, MAX48, MAX48, 1'b1));
		lights_pending.push_back(mk(2'd3, '0, '0, '0, '0, 1'b0));
		lights_pending.push_back(mk(KIND_POINT, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), MAX48,
		                            pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
		                            pack3(16'h8000, 16'h8000, 16'h8000), 1'b1));
		lights_pending.push_back(mk(KIND_DIRECTIONAL, pack3(16'h8000, 16'h8000, 16'h8000),
		                            MAX48, pack3(16'h8000, 16'h8000, 16'h8000), MAX48, 1'b1));
		// pile up sums past saturation, then close
		repeat (6) lights_pending.push_back(mk(KIND_AMBIENT, '0, MAX48, '0, '0, 1'b0));
		lights_pending.push_back(mk(KIND_DIRECTIONAL, ZUP, '0, ZUP, '0, 1'b1));
		wait_quiet();
		run_random(90);

		// Extreme low: zero coefficients, exponent zero
		set_all('0, '0, '0, 8'd0, '0);
		run_random(80);

		// Extreme high: full-scale coefficients and exponent, no idling here
		no_idle = 1'b1;
		set_all(MAX48, MAX48, MAX48, 8'd255, MAX48);
		run_random(100);
		no_idle = 1'b0;

		// Random settings
		repeat (3) begin
			set_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			        48'({$urandom, $urandom}), 8'($urandom_range(255)), rand_vec());
			run_random(100);
		end

		// Hold the sender mid-stream until every pixel is back
		set_all(HALF3, ONES3, ONES3, 8'd16, ZDN);
		repeat (40) lights_pending.push_back(rand_light());
		while (lights_pending.size() > 20) @(posedge clk);
		hold_lights = 1'b1;
		while (pixels_expected.size() != 0 || in_valid) @(posedge clk);
		hold_lights = 1'b0;
		wait_quiet();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/phong_pkg.sv
hw/rtl/phong_mul.sv
hw/rtl/phong_fragment_shader_core.sv
dv/phong_fragment_shader_core_tb.sv
